// ----- hdl/mss_pkg.sv -----
// ============================================================================
// mss_pkg - shared types and constants
// Widths, register indexes and the command/status bundles passed between
// the controller and the datapath of the bounded max-subarray block.
// ============================================================================
package mss_pkg;

    // Field widths
    localparam int SAMPLE_W        = 32;
    localparam int SUM_W           = 48;
    localparam int CFG_W           = 11;
    localparam int MAX_LEN_DEFAULT = 1024;

    // Register port
    localparam int ADDR_W  = 3;
    localparam int PDATA_W = 32;

    // Register indexes (byte address / 4)
    localparam logic [0:0] REG_MIN_LEN = 1'b0;
    localparam logic [0:0] REG_MAX_LEN = 1'b1;

    // Register reset values
    localparam logic [CFG_W-1:0] MIN_LEN_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] MAX_LEN_RESET = CFG_W'(1024);

    // Commands from controller to datapath
    typedef struct packed {
        logic take;       // accept a word, update prefix, fetch ring slot
        logic vload;      // latch window prefix, fetch deque head
        logic head_step;  // drop stale head entry
        logic head_done;  // latch head value, fetch deque tail
        logic tail_step;  // drop tail entry not below new prefix
        logic push;       // append new prefix, update best
        logic emit;       // load output register
    } mss_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic go;         // a candidate is formed for this word
        logic head_drop;  // head entry is older than max_len
        logic tail_drop;  // tail entry is not below the new prefix
        logic out_free;   // output register can take a word
    } mss_stat_t;

endpackage

// ----- hdl/mss_ctrl.sv -----
// ============================================================================
// mss_ctrl - sequencing controller
// Steps each accepted word through ring fetch, head pops, tail pops, push
// and output load, or straight to output load if it forms no candidate.
// ============================================================================
module mss_ctrl
    import mss_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mss_stat_t stat,
    output mss_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_VLOAD = 3'd1;
    localparam logic [2:0] S_HEAD  = 3'd2;
    localparam logic [2:0] S_TAIL  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Take input only between words
    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = stat.go ? S_VLOAD : S_OUT;
                end
            end
            S_VLOAD:
            begin
                cmd.vload  = 1'b1;
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                if (stat.head_drop)
                begin
                    cmd.head_step = 1'b1;
                end
                else
                begin
                    cmd.head_done = 1'b1;
                    state_next    = S_TAIL;
                end
            end
            S_TAIL:
            begin
                if (stat.tail_drop)
                begin
                    cmd.tail_step = 1'b1;
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- hdl/mss_dpath.sv -----
// ============================================================================
// mss_dpath - prefix ring, min deque and best-sum datapath
// Holds the running prefix, the ring of recent prefixes, the monotonic
// deque of window minimum candidates and the output register.
// ============================================================================
module mss_dpath
    import mss_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,
    input  logic        [CFG_W-1:0]    min_len,
    input  logic        [CFG_W-1:0]    max_len,
    input  logic                       cfg_clear,
    input  mss_cmd_t                   cmd,
    output mss_stat_t                  stat,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [SUM_W-1:0]    best_sum,
    output logic                       best_valid,
    output logic                       end_of_run
);

    localparam int RING = MAX_LEN + 1;
    localparam int IW   = $clog2(MAX_LEN + 1);
    localparam int CW   = IW + 1;
    localparam int DQ_W = CW + SUM_W;
    localparam logic [IW:0]   RING_W  = (IW + 1)'(RING);
    localparam logic [IW-1:0] LAST_IX = IW'(MAX_LEN);

    // Ring index step with wrap
    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] x);
        return (x == LAST_IX) ? '0 : x + 1'b1;
    endfunction

    function automatic logic [IW-1:0] wrap_dec(input logic [IW-1:0] x);
        return (x == '0) ? LAST_IX : x - 1'b1;
    endfunction

    // Sequence state
    logic [SUM_W-1:0] prefix_reg;
    logic [IW-1:0]    rp_reg;
    logic [CW-1:0]    count_reg;
    logic [IW-1:0]    head_reg;
    logic [IW-1:0]    tail_reg;
    logic [SUM_W-1:0] best_reg;
    logic             have_best_reg;

    // Per-word working registers
    logic             last_reg;
    logic [SUM_W-1:0] v_reg;
    logic [CW-1:0]    jpos_reg;
    logic [SUM_W-1:0] head_val_reg;

    // Memories
    logic [SUM_W-1:0] ring_mem [RING];
    logic [DQ_W-1:0]  dq_mem   [RING];
    logic [SUM_W-1:0] ring_rdata;
    logic [DQ_W-1:0]  dq_rdata;
    logic [IW-1:0]    dq_raddr;

    // Output register
    logic             out_valid_reg;
    logic [SUM_W-1:0] best_sum_reg;
    logic             best_valid_reg;
    logic             eor_reg;

    // Combinational helpers
    logic [IW-1:0]    len_a;
    logic [IW-1:0]    len_b;
    logic             bounds_ok;
    logic [SUM_W-1:0] prefix_next;
    logic [IW-1:0]    rp_inc;
    logic [CW-1:0]    count_inc;
    logic [IW:0]      slot_wide;
    logic [IW-1:0]    slot;
    logic [IW-1:0]    head_inc;
    logic [IW-1:0]    tail_dec;
    logic [CW-1:0]    rd_pos;
    logic [SUM_W-1:0] rd_val;
    logic [CW-1:0]    age;
    logic             dq_empty;
    logic [SUM_W-1:0] min_val;
    logic [SUM_W-1:0] cand;
    logic             better;
    logic             seq_clear;

    // Clamp bounds to [1, MAX_LEN]
    always_comb
    begin
        if (min_len == '0)
            len_a = IW'(1);
        else if (32'(min_len) > MAX_LEN)
            len_a = LAST_IX;
        else
            len_a = IW'(min_len);

        if (max_len == '0)
            len_b = IW'(1);
        else if (32'(max_len) > MAX_LEN)
            len_b = LAST_IX;
        else
            len_b = IW'(max_len);
    end

    assign bounds_ok = (len_a <= len_b);

    // Prefix update and ring slot of the prefix min_len back
    assign prefix_next = prefix_reg + {{(SUM_W - SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
    assign rp_inc      = wrap_inc(rp_reg);
    assign count_inc   = count_reg + 1'b1;
    assign slot_wide   = {1'b0, rp_inc} + ((rp_inc < len_a) ? RING_W : '0) - {1'b0, len_a};
    assign slot        = slot_wide[IW-1:0];
    assign head_inc    = wrap_inc(head_reg);
    assign tail_dec    = wrap_dec(tail_reg);

    // Deque read address follows the step being taken
    always_comb
    begin
        dq_raddr = head_reg;
        if (cmd.head_step)
            dq_raddr = head_inc;
        else if (cmd.head_done)
            dq_raddr = tail_dec;
        else if (cmd.tail_step)
            dq_raddr = wrap_dec(tail_dec);
    end

    // Ring memory: write newest prefix, read window prefix
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            ring_mem[rp_inc] <= prefix_next;
            ring_rdata       <= ring_mem[slot];
        end
    end

    // Deque memory: entries are {position, prefix}
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            dq_mem[tail_reg] <= {jpos_reg, v_reg};
        dq_rdata <= dq_mem[dq_raddr];
    end

    assign rd_pos   = dq_rdata[DQ_W-1:SUM_W];
    assign rd_val   = dq_rdata[SUM_W-1:0];
    assign age      = count_reg - rd_pos;
    assign dq_empty = (head_reg == tail_reg);

    // Candidate against window minimum
    assign min_val = dq_empty ? v_reg : head_val_reg;
    assign cand    = prefix_reg - min_val;
    assign better  = !have_best_reg || ($signed(best_reg) < $signed(cand));

    // Status
    assign stat.go        = bounds_ok && (have_best_reg || (count_inc >= CW'(len_a)));
    assign stat.head_drop = !dq_empty && (age > CW'(len_b));
    assign stat.tail_drop = !dq_empty && !($signed(rd_val) < $signed(v_reg));
    assign stat.out_free  = !out_valid_reg || out_ready;

    assign seq_clear = cfg_clear || (cmd.emit && last_reg);

    // Sequence state: advance per command, clear on last or register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_reg    <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            best_reg      <= '0;
            have_best_reg <= 1'b0;
        end
        else if (seq_clear)
        begin
            prefix_reg    <= '0;
            rp_reg        <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            best_reg      <= '0;
            have_best_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take)
            begin
                prefix_reg <= prefix_next;
                rp_reg     <= rp_inc;
                count_reg  <= count_inc;
            end
            if (cmd.head_step)
                head_reg <= head_inc;
            if (cmd.tail_step)
                tail_reg <= tail_dec;
            if (cmd.push)
            begin
                tail_reg      <= wrap_inc(tail_reg);
                have_best_reg <= 1'b1;
                if (better)
                    best_reg <= cand;
            end
        end
    end

    // Working registers for the word in flight
    always_ff @(posedge clk)
    begin
        if (cmd.take)
            last_reg <= last;
        if (cmd.vload)
        begin
            // The first window prefix is the empty prefix, always zero
            v_reg    <= have_best_reg ? ring_rdata : '0;
            jpos_reg <= count_reg - CW'(len_a);
        end
        if (cmd.head_done)
            head_val_reg <= rd_val;
    end

    // Output register: hold word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            best_sum_reg   <= best_reg;
            best_valid_reg <= have_best_reg && bounds_ok;
            eor_reg        <= last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign best_sum   = $signed(best_sum_reg);
    assign best_valid = best_valid_reg;
    assign end_of_run = eor_reg;

endmodule

// ----- hdl/max_subarray_sum_len_bounded_core.sv -----
// ============================================================================
// max_subarray_sum_len_bounded_core - length-bounded maximum subarray sum
// Streams signed samples and reports, for each one, the best sum of a
// contiguous run whose length lies between min_len and max_len.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready, sample, last) takes one word per
//   sample; last ends a sequence and clears the running state after its
//   result. Output channel (out_valid/out_ready) returns one word per input
//   word: best_sum, best_valid and end_of_run.
//   min_len and max_len sit at byte addresses 0 and 4 of the APB port;
//   any write also clears the running state. Write only while idle.
// Timing:
//   A word that forms no candidate (too few samples, or min_len above
//   max_len) goes from the take straight to the output load. Any other
//   word also takes the ring fetch, the H stale entries dropped from the
//   deque head, the T dropped from the tail, one per cycle through the
//   single deque memory port, then the push; H + T averages at most 2
//   per word. The result shows in the cycle the next word can be taken.
// Reset and stalls:
//   Reset sets min_len = 1, max_len = 1024 and empties the sequence.
//   The output register holds a word until it is taken; a second word
//   is accepted and worked while the first waits, then holds until free.
// ============================================================================
module max_subarray_sum_len_bounded_core
    import mss_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEFAULT
)
(
    input  logic                       clk,
    input  logic                       rst_n,

    // Register port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic        [ADDR_W-1:0]   paddr,
    input  logic        [PDATA_W-1:0]  pwdata,
    output logic        [PDATA_W-1:0]  prdata,
    output logic                       pready,

    // Input channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic                       last,

    // Output channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SUM_W-1:0]    best_sum,
    output logic                       best_valid,
    output logic                       end_of_run
);

    logic [CFG_W-1:0] min_len_reg;
    logic [CFG_W-1:0] max_len_reg;
    logic             cfg_wr;
    logic [0:0]       reg_idx;
    mss_cmd_t         cmd;
    mss_stat_t        stat;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_len_reg <= MIN_LEN_RESET;
            max_len_reg <= MAX_LEN_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MIN_LEN: min_len_reg <= pwdata[CFG_W-1:0];
                REG_MAX_LEN: max_len_reg <= pwdata[CFG_W-1:0];
                default:     ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        case (reg_idx)
            REG_MIN_LEN: prdata = PDATA_W'(min_len_reg);
            REG_MAX_LEN: prdata = PDATA_W'(max_len_reg);
            default:     prdata = '0;
        endcase
    end

    mss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mss_dpath #(
        .MAX_LEN (MAX_LEN)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample     (sample),
        .last       (last),
        .min_len    (min_len_reg),
        .max_len    (max_len_reg),
        .cfg_clear  (cfg_wr),
        .cmd        (cmd),
        .stat       (stat),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .best_sum   (best_sum),
        .best_valid (best_valid),
        .end_of_run (end_of_run)
    );

endmodule
